// ===== rtl/gbs_pkg.sv =====
package gbs_pkg;

  typedef enum logic [1:0] {
    RQ_ATTRACT = 2'd0,
    RQ_ADVANCE = 2'd1,
    RQ_SETACC  = 2'd2,
    RQ_LOAD    = 2'd3
  } rtype_t;

  typedef enum logic [0:0] {
    CFG_GRAV  = 1'b0,
    CFG_TSTEP = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_PRE, ST_ZCHK, ST_SQRT, ST_POST,
    ST_DIV, ST_ACC, ST_ADV, ST_POS, ST_DONE
  } state_t;

  // multiplier operations, each retired in the cycle after issue
  typedef enum logic [4:0] {
    MOP_NONE, MOP_DXX, MOP_DYY, MOP_GM, MOP_NXL, MOP_NXH, MOP_NYL, MOP_NYH,
    MOP_DL, MOP_DH, MOP_AXT, MOP_AYT, MOP_HXL, MOP_HXH, MOP_HYL, MOP_HYH,
    MOP_VXT, MOP_VYT
  } mop_t;

  typedef struct packed {
    logic   accept;
    logic   diff;
    mop_t   mop;
    logic   coin_set;
    logic   sq_init;
    logic   sq_step;
    logic   div_init;
    logic   div_step;
    logic   acc_upd;
    logic   pos_upd;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        other_mass;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic signed [31:0] set_ax;
    logic signed [31:0] set_ay;
    logic signed [31:0] load_x;
    logic signed [31:0] load_y;
    logic signed [31:0] load_vx;
    logic signed [31:0] load_vy;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic               coincident;
    logic               saturated;
  } res_t;

  localparam logic [31:0] ONE_Q824 = 32'h0100_0000;
  localparam logic [34:0] QCLAMP = 35'h2_0000_0000;
  localparam logic signed [49:0] SMAX50 = 50'sd2147483647;
  localparam logic signed [49:0] SMIN50 = -50'sd2147483648;

  localparam logic [6:0] PRE_LAST  = 7'd2;
  localparam logic [6:0] SQRT_LAST = 7'd32;
  localparam logic [6:0] POST_LAST = 7'd8;
  localparam logic [6:0] DIV_LAST  = 7'd104;
  localparam logic [6:0] ADV_LAST  = 7'd8;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [49:0] sx50(input logic signed [31:0] v);
    return {{18{v[31]}}, v};
  endfunction

  // msb is the clamp flag
  function automatic logic [32:0] clamp32(input logic signed [49:0] v);
    if (v > SMAX50) return {1'b1, 32'h7fff_ffff};
    if (v < SMIN50) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic mop_t pre_op(input logic [1:0] i);
    case (i)
      2'd0: return MOP_DXX;
      2'd1: return MOP_DYY;
      default: return MOP_NONE;
    endcase
  endfunction

  function automatic mop_t post_op(input logic [3:0] i);
    case (i)
      4'd0: return MOP_GM;
      4'd2: return MOP_NXL;
      4'd3: return MOP_NXH;
      4'd4: return MOP_NYL;
      4'd5: return MOP_NYH;
      4'd6: return MOP_DL;
      4'd7: return MOP_DH;
      default: return MOP_NONE;
    endcase
  endfunction

  function automatic mop_t adv_op(input logic [3:0] i);
    case (i)
      4'd0: return MOP_AXT;
      4'd1: return MOP_AYT;
      4'd2: return MOP_HXL;
      4'd3: return MOP_HXH;
      4'd4: return MOP_HYL;
      4'd5: return MOP_HYH;
      4'd6: return MOP_VXT;
      4'd7: return MOP_VYT;
      default: return MOP_NONE;
    endcase
  endfunction

endpackage

// ===== rtl/gbs_if.sv =====
interface gbs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [31:0]        other_mass;
  logic signed [31:0] other_x;
  logic signed [31:0] other_y;
  logic signed [31:0] set_ax;
  logic signed [31:0] set_ay;
  logic signed [31:0] load_x;
  logic signed [31:0] load_y;
  logic signed [31:0] load_vx;
  logic signed [31:0] load_vy;

  modport source(output valid, req_type, other_mass, other_x, other_y, set_ax, set_ay,
                 load_x, load_y, load_vx, load_vy, input ready);
  modport sink(input valid, req_type, other_mass, other_x, other_y, set_ax, set_ay,
               load_x, load_y, load_vx, load_vy, output ready);
endinterface

interface gbs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic               coincident;
  logic               saturated;

  modport source(output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, coincident,
                 saturated, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y, coincident,
               saturated, output ready);
endinterface

// ===== rtl/gbs_ctrl.sv =====
module gbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [1:0]       req_type,
  output logic             req_ready,
  input  logic             out_ready,
  output logic             out_valid,
  input  logic             s_zero,
  output gbs_pkg::cmd_t    cmd
);

  gbs_pkg::state_t state, state_next;
  logic [6:0] cnt, cnt_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gbs_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mop    = gbs_pkg::MOP_NONE;
    req_ready  = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      gbs_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          cnt_next   = '0;
          case (gbs_pkg::rtype_t'(req_type))
            gbs_pkg::RQ_ATTRACT: state_next = gbs_pkg::ST_DIFF;
            gbs_pkg::RQ_ADVANCE: state_next = gbs_pkg::ST_ADV;
            default:             state_next = gbs_pkg::ST_DONE;
          endcase
        end
      end
      gbs_pkg::ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = gbs_pkg::ST_PRE;
      end
      gbs_pkg::ST_PRE: begin
        cmd.mop  = gbs_pkg::pre_op(cnt[1:0]);
        cnt_next = cnt + 7'd1;
        if (cnt == gbs_pkg::PRE_LAST) begin
          cnt_next   = '0;
          state_next = gbs_pkg::ST_ZCHK;
        end
      end
      gbs_pkg::ST_ZCHK: begin
        if (s_zero) begin
          cmd.coin_set = 1'b1;
          state_next   = gbs_pkg::ST_DONE;
        end else begin
          cmd.sq_init = 1'b1;
          state_next  = gbs_pkg::ST_SQRT;
        end
      end
      gbs_pkg::ST_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_next    = cnt + 7'd1;
        if (cnt == gbs_pkg::SQRT_LAST) begin
          cnt_next   = '0;
          state_next = gbs_pkg::ST_POST;
        end
      end
      gbs_pkg::ST_POST: begin
        cmd.mop  = gbs_pkg::post_op(cnt[3:0]);
        cnt_next = cnt + 7'd1;
        if (cnt == gbs_pkg::POST_LAST) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = gbs_pkg::ST_DIV;
        end
      end
      gbs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 7'd1;
        if (cnt == gbs_pkg::DIV_LAST) begin
          cnt_next   = '0;
          state_next = gbs_pkg::ST_ACC;
        end
      end
      gbs_pkg::ST_ACC: begin
        cmd.acc_upd = 1'b1;
        state_next  = gbs_pkg::ST_DONE;
      end
      gbs_pkg::ST_ADV: begin
        cmd.mop  = gbs_pkg::adv_op(cnt[3:0]);
        cnt_next = cnt + 7'd1;
        if (cnt == gbs_pkg::ADV_LAST) begin
          cnt_next   = '0;
          state_next = gbs_pkg::ST_POS;
        end
      end
      gbs_pkg::ST_POS: begin
        cmd.pos_upd = 1'b1;
        state_next  = gbs_pkg::ST_DONE;
      end
      gbs_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = gbs_pkg::ST_IDLE;
        end
      end
      default: state_next = gbs_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/gbs_datapath.sv =====
module gbs_datapath (
  input  logic          clk,
  input  logic          rst,
  input  gbs_pkg::cmd_t cmd,
  input  gbs_pkg::in_t  din,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          s_zero,
  output gbs_pkg::res_t res
);

  logic [31:0] grav, tstep;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic [31:0] mass;
  logic signed [31:0] oth_x, oth_y;
  logic [32:0] mdx, mdy;
  logic sdx, sdy;
  logic [65:0] s, sq_src;
  logic [34:0] sq_rem;
  logic [32:0] r;
  logic [63:0] gm, px, py;
  logic [96:0] numx, numy;
  logic [98:0] den;
  logic [95:0] hx, hy;
  logic [39:0] vdtx, vdty;
  logic [104:0] nshx, nshy;
  logic [98:0] drx, dry;
  logic [34:0] qx, qy;
  logic ovx, ovy;
  logic [65:0] prod;
  gbs_pkg::mop_t mop_q;
  logic sat, coin;

  logic signed [32:0] dxw, dyw;
  logic [32:0] ma, mb;
  logic [36:0] rem2, trial;
  logic [99:0] r2x, r2y;
  logic gex, gey;
  logic [33:0] mx, my;
  logic [32:0] vnew, axn, ayn, pxn, pyn;
  logic signed [49:0] vterm, aterm_x, aterm_y, pterm_x, pterm_y;
  logic vsel_x;

  assign s_zero = (s == '0);

  always_comb begin
    dxw = {oth_x[31], oth_x} - {pos_x[31], pos_x};
    dyw = {oth_y[31], oth_y} - {pos_y[31], pos_y};
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mop)
      gbs_pkg::MOP_DXX: begin ma = mdx; mb = mdx; end
      gbs_pkg::MOP_DYY: begin ma = mdy; mb = mdy; end
      gbs_pkg::MOP_GM:  begin ma = {1'b0, grav}; mb = {1'b0, mass}; end
      gbs_pkg::MOP_NXL: begin ma = {1'b0, gm[31:0]}; mb = mdx; end
      gbs_pkg::MOP_NXH: begin ma = {1'b0, gm[63:32]}; mb = mdx; end
      gbs_pkg::MOP_NYL: begin ma = {1'b0, gm[31:0]}; mb = mdy; end
      gbs_pkg::MOP_NYH: begin ma = {1'b0, gm[63:32]}; mb = mdy; end
      gbs_pkg::MOP_DL:  begin ma = s[32:0]; mb = r; end
      gbs_pkg::MOP_DH:  begin ma = s[65:33]; mb = r; end
      gbs_pkg::MOP_AXT: begin ma = {1'b0, gbs_pkg::mag32(acc_x)}; mb = {1'b0, tstep}; end
      gbs_pkg::MOP_AYT: begin ma = {1'b0, gbs_pkg::mag32(acc_y)}; mb = {1'b0, tstep}; end
      gbs_pkg::MOP_HXL: begin ma = {1'b0, px[31:0]}; mb = {1'b0, tstep}; end
      gbs_pkg::MOP_HXH: begin ma = {1'b0, px[63:32]}; mb = {1'b0, tstep}; end
      gbs_pkg::MOP_HYL: begin ma = {1'b0, py[31:0]}; mb = {1'b0, tstep}; end
      gbs_pkg::MOP_HYH: begin ma = {1'b0, py[63:32]}; mb = {1'b0, tstep}; end
      gbs_pkg::MOP_VXT: begin ma = {1'b0, gbs_pkg::mag32(vel_x)}; mb = {1'b0, tstep}; end
      gbs_pkg::MOP_VYT: begin ma = {1'b0, gbs_pkg::mag32(vel_y)}; mb = {1'b0, tstep}; end
      default: ;
    endcase
  end

  always_comb begin
    // velocity update retires from the a*dt product
    vsel_x = (mop_q == gbs_pkg::MOP_AXT);
    vterm  = $signed({10'b0, prod[63:24]});
    if (vsel_x ? acc_x[31] : acc_y[31]) vterm = -vterm;
    vnew = gbs_pkg::clamp32(gbs_pkg::sx50(vsel_x ? vel_x : vel_y) + vterm);

    // isqrt step, two radicand bits at a time
    rem2  = {sq_rem, sq_src[65:64]};
    trial = {2'b0, r, 2'b01};

    r2x = {drx, nshx[104]};
    r2y = {dry, nshy[104]};
    gex = (r2x >= {1'b0, den});
    gey = (r2y >= {1'b0, den});

    mx = (ovx || qx > gbs_pkg::QCLAMP) ? gbs_pkg::QCLAMP[33:0] : qx[33:0];
    my = (ovy || qy > gbs_pkg::QCLAMP) ? gbs_pkg::QCLAMP[33:0] : qy[33:0];
    aterm_x = $signed({16'b0, mx});
    aterm_y = $signed({16'b0, my});
    if (sdx) aterm_x = -aterm_x;
    if (sdy) aterm_y = -aterm_y;
    axn = gbs_pkg::clamp32(gbs_pkg::sx50(acc_x) + aterm_x);
    ayn = gbs_pkg::clamp32(gbs_pkg::sx50(acc_y) + aterm_y);

    pterm_x = $signed({10'b0, vdtx});
    pterm_y = $signed({10'b0, vdty});
    if (vel_x[31]) pterm_x = -pterm_x;
    if (vel_y[31]) pterm_y = -pterm_y;
    pxn = gbs_pkg::clamp32(gbs_pkg::sx50(pos_x) + pterm_x
          + (acc_x[31] ? -$signed({3'b0, hx[95:49]}) : $signed({3'b0, hx[95:49]})));
    pyn = gbs_pkg::clamp32(gbs_pkg::sx50(pos_y) + pterm_y
          + (acc_y[31] ? -$signed({3'b0, hy[95:49]}) : $signed({3'b0, hy[95:49]})));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grav  <= gbs_pkg::ONE_Q824;
      tstep <= gbs_pkg::ONE_Q824;
    end else if (cfg_we) begin
      case (gbs_pkg::cfg_idx_t'(cfg_index))
        gbs_pkg::CFG_GRAV:  grav  <= cfg_data;
        gbs_pkg::CFG_TSTEP: tstep <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0; pos_y <= '0;
      vel_x <= '0; vel_y <= '0;
      acc_x <= '0; acc_y <= '0;
      mop_q <= gbs_pkg::MOP_NONE;
      sat   <= 1'b0;
      coin  <= 1'b0;
    end else begin
      mop_q <= cmd.mop;
      if (cmd.accept) begin
        sat  <= 1'b0;
        coin <= 1'b0;
        case (gbs_pkg::rtype_t'(din.req_type))
          gbs_pkg::RQ_SETACC: begin
            acc_x <= din.set_ax;
            acc_y <= din.set_ay;
          end
          gbs_pkg::RQ_LOAD: begin
            pos_x <= din.load_x;
            pos_y <= din.load_y;
            vel_x <= din.load_vx;
            vel_y <= din.load_vy;
          end
          default: ;
        endcase
      end
      if (cmd.coin_set) coin <= 1'b1;
      case (mop_q)
        gbs_pkg::MOP_AXT: begin
          vel_x <= vnew[31:0];
          if (vnew[32]) sat <= 1'b1;
        end
        gbs_pkg::MOP_AYT: begin
          vel_y <= vnew[31:0];
          if (vnew[32]) sat <= 1'b1;
        end
        default: ;
      endcase
      if (cmd.acc_upd) begin
        acc_x <= axn[31:0];
        acc_y <= ayn[31:0];
        if (axn[32] || ayn[32]) sat <= 1'b1;
      end
      if (cmd.pos_upd) begin
        pos_x <= pxn[31:0];
        pos_y <= pyn[31:0];
        if (pxn[32] || pyn[32]) sat <= 1'b1;
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    prod <= {33'b0, ma} * {33'b0, mb};
    if (cmd.accept) begin
      mass  <= din.other_mass;
      oth_x <= din.other_x;
      oth_y <= din.other_y;
    end
    if (cmd.diff) begin
      sdx <= dxw[32];
      sdy <= dyw[32];
      mdx <= dxw[32] ? 33'(-dxw) : 33'(dxw);
      mdy <= dyw[32] ? 33'(-dyw) : 33'(dyw);
    end
    case (mop_q)
      gbs_pkg::MOP_DXX: s    <= prod;
      gbs_pkg::MOP_DYY: s    <= s + prod;
      gbs_pkg::MOP_GM:  gm   <= prod[63:0];
      gbs_pkg::MOP_NXL: numx <= {31'b0, prod};
      gbs_pkg::MOP_NXH: numx <= numx + {prod[64:0], 32'b0};
      gbs_pkg::MOP_NYL: numy <= {31'b0, prod};
      gbs_pkg::MOP_NYH: numy <= numy + {prod[64:0], 32'b0};
      gbs_pkg::MOP_DL:  den  <= {33'b0, prod};
      gbs_pkg::MOP_DH:  den  <= den + {prod, 33'b0};
      gbs_pkg::MOP_AXT: px   <= prod[63:0];
      gbs_pkg::MOP_AYT: py   <= prod[63:0];
      gbs_pkg::MOP_HXL: hx   <= {30'b0, prod};
      gbs_pkg::MOP_HXH: hx   <= hx + {prod[63:0], 32'b0};
      gbs_pkg::MOP_HYL: hy   <= {30'b0, prod};
      gbs_pkg::MOP_HYH: hy   <= hy + {prod[63:0], 32'b0};
      gbs_pkg::MOP_VXT: vdtx <= prod[63:24];
      gbs_pkg::MOP_VYT: vdty <= prod[63:24];
      default: ;
    endcase
    if (cmd.sq_init) begin
      sq_src <= s;
      sq_rem <= '0;
      r      <= '0;
    end
    if (cmd.sq_step) begin
      sq_src <= {sq_src[63:0], 2'b00};
      if (rem2 >= trial) begin
        sq_rem <= 35'(rem2 - trial);
        r      <= {r[31:0], 1'b1};
      end else begin
        sq_rem <= rem2[34:0];
        r      <= {r[31:0], 1'b0};
      end
    end
    if (cmd.div_init) begin
      nshx <= {numx, 8'b0};
      nshy <= {numy, 8'b0};
      drx  <= '0;
      dry  <= '0;
      qx   <= '0;
      qy   <= '0;
      ovx  <= 1'b0;
      ovy  <= 1'b0;
    end
    if (cmd.div_step) begin
      nshx <= {nshx[103:0], 1'b0};
      nshy <= {nshy[103:0], 1'b0};
      drx  <= gex ? 99'(r2x - {1'b0, den}) : r2x[98:0];
      dry  <= gey ? 99'(r2y - {1'b0, den}) : r2y[98:0];
      qx   <= {qx[33:0], gex};
      qy   <= {qy[33:0], gey};
      // quotient bits past the clamp only mark overflow
      if (qx[34]) ovx <= 1'b1;
      if (qy[34]) ovy <= 1'b1;
    end
    if (cmd.out_load) begin
      res.pos_x      <= pos_x;
      res.pos_y      <= pos_y;
      res.vel_x      <= vel_x;
      res.vel_y      <= vel_y;
      res.acc_x      <= acc_x;
      res.acc_y      <= acc_y;
      res.coincident <= coin;
      res.saturated  <= sat;
    end
  end

endmodule

// ===== rtl/gravity_body_step_top.sv =====
// channel | dir | handshake     | payload
// req     | in  | valid / ready | req_type, other_mass, other_x/y, set_ax/y, load_x/y/vx/vy
// rsp     | out | valid / ready | pos_x/y, vel_x/y, acc_x/y, coincident, saturated
// cfg     | in  | cfg_we        | cfg_index, cfg_data (grav_const, time_step)
//
// one item at a time; attract is dominated by the 33-step square root and the 105-step
// bit-serial divide (both axes divide side by side)
// advance runs through the shared 33x33 multiplier; set/load write the state directly
// a finished item sits in the output register; a new item is taken while it waits
// synchronous active-high reset clears the body state and sets both registers to 1.0
module gravity_body_step_top (
  input  logic        clk,
  input  logic        rst,
  gbs_req_if.sink     req,
  gbs_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  gbs_pkg::cmd_t cmd;
  gbs_pkg::in_t  din;
  gbs_pkg::res_t res;
  logic s_zero;

  assign din.req_type   = req.req_type;
  assign din.other_mass = req.other_mass;
  assign din.other_x    = req.other_x;
  assign din.other_y    = req.other_y;
  assign din.set_ax     = req.set_ax;
  assign din.set_ay     = req.set_ay;
  assign din.load_x     = req.load_x;
  assign din.load_y     = req.load_y;
  assign din.load_vx    = req.load_vx;
  assign din.load_vy    = req.load_vy;

  assign rsp.pos_x      = res.pos_x;
  assign rsp.pos_y      = res.pos_y;
  assign rsp.vel_x      = res.vel_x;
  assign rsp.vel_y      = res.vel_y;
  assign rsp.acc_x      = res.acc_x;
  assign rsp.acc_y      = res.acc_y;
  assign rsp.coincident = res.coincident;
  assign rsp.saturated  = res.saturated;

  gbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .s_zero    (s_zero),
    .cmd       (cmd)
  );

  gbs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .din       (din),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_zero    (s_zero),
    .res       (res)
  );

`ifndef SYNTH
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready) else $error("item taken while busy");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.coincident && rsp.saturated))
    else $error("coincident item reported saturation");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !rsp.valid) else $error("output valid after reset");
`endif

endmodule

// ===== bench/tb_gravity_body_step_top.sv =====
module tb_gravity_body_step_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 1000000;
  localparam int DRAIN = 200;
  localparam logic [31:0] PMAX = 32'h7fff_ffff;
  localparam logic [31:0] PMIN = 32'h8000_0000;

  typedef struct {
    gbs_pkg::in_t  item;
    bit            typed;
    gbs_pkg::res_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  gbs_req_if req_if();
  gbs_rsp_if rsp_if();

  gravity_body_step_top u_top (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // body state and registers as the block should hold them
  logic signed [31:0] body_px, body_py, body_vx, body_vy, body_ax, body_ay;
  logic [31:0]        grav_reg, step_reg;

  gbs_pkg::res_t state_q[$];
  int   fails = 0;
  int   n_items = 0, n_results = 0, n_coin = 0, n_sat = 0;
  int   cycles = 0;
  bit   no_idle = 0;
  bit   hold_pending = 0;
  int   hold_left = 0, rsp_stall = 0;

  function automatic logic [32:0] fit32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return {1'b1, 32'h7fff_ffff};
    if (v < -128'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] v);
    logic [127:0] r, c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // trunc(a * t / 2^s) toward zero
  function automatic logic signed [127:0] scaled(input logic signed [127:0] a,
                                                 input logic [31:0] t, input int s);
    logic [127:0] m;
    m = ((a < 0 ? -a : a) * {96'd0, t}) >> s;
    return a < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [127:0] pull_mag(input logic [127:0] gm, input logic [127:0] d,
                                            input logic [127:0] den);
    logic [127:0] q;
    q = ((gm * d) << 8) / den;
    return q > 128'h2_0000_0000 ? 128'h2_0000_0000 : q;
  endfunction

  function automatic logic [31:0] mag_of(input logic signed [31:0] v);
    return v < 0 ? 32'(-v) : 32'(v);
  endfunction

  task automatic body_update(input gbs_pkg::in_t it, output gbs_pkg::res_t r);
    logic signed [127:0] dx, dy, hx, hy;
    logic [127:0] ux, uy, s, rt, gm, den, qx, qy, px, py;
    logic [32:0] f;
    bit sat, coin;
    sat = 0;
    coin = 0;
    case (gbs_pkg::rtype_t'(it.req_type))
      gbs_pkg::RQ_ATTRACT: begin
        dx = $signed(it.other_x) - $signed(body_px);
        dy = $signed(it.other_y) - $signed(body_py);
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        s = ux * ux + uy * uy;
        if (s == 0) begin
          coin = 1;
        end else begin
          rt = root_floor(s);
          gm = {96'd0, grav_reg} * {96'd0, it.other_mass};
          den = s * rt;
          qx = pull_mag(gm, ux, den);
          qy = pull_mag(gm, uy, den);
          f = fit32($signed(body_ax) + (dx < 0 ? -$signed(qx) : $signed(qx)));
          body_ax = f[31:0]; sat |= f[32];
          f = fit32($signed(body_ay) + (dy < 0 ? -$signed(qy) : $signed(qy)));
          body_ay = f[31:0]; sat |= f[32];
        end
      end
      gbs_pkg::RQ_ADVANCE: begin
        f = fit32($signed(body_vx) + scaled(body_ax, step_reg, 24));
        body_vx = f[31:0]; sat |= f[32];
        f = fit32($signed(body_vy) + scaled(body_ay, step_reg, 24));
        body_vy = f[31:0]; sat |= f[32];
        px = {96'd0, mag_of(body_ax)} * {96'd0, step_reg};
        py = {96'd0, mag_of(body_ay)} * {96'd0, step_reg};
        hx = scaled(body_ax < 0 ? -$signed(px) : $signed(px), step_reg, 49);
        hy = scaled(body_ay < 0 ? -$signed(py) : $signed(py), step_reg, 49);
        f = fit32($signed(body_px) + scaled(body_vx, step_reg, 24) + hx);
        body_px = f[31:0]; sat |= f[32];
        f = fit32($signed(body_py) + scaled(body_vy, step_reg, 24) + hy);
        body_py = f[31:0]; sat |= f[32];
      end
      gbs_pkg::RQ_SETACC: begin
        body_ax = it.set_ax;
        body_ay = it.set_ay;
      end
      default: begin
        body_px = it.load_x;
        body_py = it.load_y;
        body_vx = it.load_vx;
        body_vy = it.load_vy;
      end
    endcase
    r = '{body_px, body_py, body_vx, body_vy, body_ax, body_ay, coin, sat};
  endtask

  function automatic gbs_pkg::in_t mk_item(input gbs_pkg::rtype_t rq, input logic [31:0] m,
                                  input logic [31:0] ox, input logic [31:0] oy,
                                  input logic [31:0] sx, input logic [31:0] sy,
                                  input logic [31:0] lx, input logic [31:0] ly,
                                  input logic [31:0] lvx, input logic [31:0] lvy);
    return '{rq, m, ox, oy, sx, sy, lx, ly, lvx, lvy};
  endfunction

  function automatic gbs_pkg::res_t mk_res(input logic [31:0] px, input logic [31:0] py,
                                  input logic [31:0] vx, input logic [31:0] vy,
                                  input logic [31:0] ax, input logic [31:0] ay,
                                  input bit c, input bit s);
    return '{px, py, vx, vy, ax, ay, c, s};
  endfunction

  // spread of magnitudes from tiny to full scale, extremes now and then
  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'($urandom_range(0, 3));
      default: return 32'($signed($urandom) >>> $urandom_range(4, 30));
    endcase
  endfunction

  function automatic gbs_pkg::in_t rnd_item(input bit noise);
    gbs_pkg::in_t it;
    int  k;
    it = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
    if (noise) return it;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      it.req_type = gbs_pkg::RQ_ATTRACT;
      it.other_mass = $urandom >> $urandom_range(0, 31);
      it.other_x = $signed(body_px) + 32'(rnd_val());
      it.other_y = $signed(body_py) + 32'(rnd_val());
      if ($urandom_range(0, 19) == 0) begin
        it.other_x = body_px;
        it.other_y = body_py;
      end
    end else if (k < 70) begin
      it.req_type = gbs_pkg::RQ_ADVANCE;
    end else if (k < 85) begin
      it.req_type = gbs_pkg::RQ_SETACC;
      it.set_ax = rnd_val();
      it.set_ay = rnd_val();
    end else begin
      it.req_type = gbs_pkg::RQ_LOAD;
      it.load_x = rnd_val();
      it.load_y = rnd_val();
      it.load_vx = rnd_val();
      it.load_vy = rnd_val();
    end
    return it;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", n_results, what, got, want);
    fails++;
  endtask

  // sender: drive at the falling edge, the item is taken at a rising edge with ready
  task automatic send_item(input gbs_pkg::in_t it, input bit typed,
                           input gbs_pkg::res_t typed_res);
    gbs_pkg::res_t r;
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.req_type <= it.req_type;
    req_if.other_mass <= it.other_mass;
    req_if.other_x <= it.other_x;
    req_if.other_y <= it.other_y;
    req_if.set_ax <= it.set_ax;
    req_if.set_ay <= it.set_ay;
    req_if.load_x <= it.load_x;
    req_if.load_y <= it.load_y;
    req_if.load_vx <= it.load_vx;
    req_if.load_vy <= it.load_vy;
    do @(posedge clk); while (!req_if.ready);
    body_update(it, r);
    state_q.push_back(typed ? typed_res : r);
    n_items++;
  endtask

  task automatic send_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    send_gap(1);
    while (state_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input gbs_pkg::cfg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gbs_pkg::CFG_GRAV) grav_reg = v;
    else step_reg = v;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(rnd_item($urandom_range(0, 9) == 0), 0, '0);
      if (!no_idle && $urandom_range(0, 3) == 0) send_gap($urandom_range(1, 6));
    end
  endtask

  // receiver ready, with random stall bursts and one long hold-off
  always @(negedge clk) begin
    if (hold_pending) begin
      hold_pending = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (no_idle) begin
      rsp_if.ready <= 1'b1;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      rsp_stall = $urandom_range(0, 5);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    gbs_pkg::res_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (state_q.size() == 0) begin
        report("unexpected result pos_x", rsp_if.pos_x, 32'h0);
      end else begin
        want = state_q.pop_front();
        if (rsp_if.pos_x !== want.pos_x) report("pos_x", rsp_if.pos_x, want.pos_x);
        if (rsp_if.pos_y !== want.pos_y) report("pos_y", rsp_if.pos_y, want.pos_y);
        if (rsp_if.vel_x !== want.vel_x) report("vel_x", rsp_if.vel_x, want.vel_x);
        if (rsp_if.vel_y !== want.vel_y) report("vel_y", rsp_if.vel_y, want.vel_y);
        if (rsp_if.acc_x !== want.acc_x) report("acc_x", rsp_if.acc_x, want.acc_x);
        if (rsp_if.acc_y !== want.acc_y) report("acc_y", rsp_if.acc_y, want.acc_y);
        if (rsp_if.coincident !== want.coincident)
          report("coincident", 32'(rsp_if.coincident), 32'(want.coincident));
        if (rsp_if.saturated !== want.saturated)
          report("saturated", 32'(rsp_if.saturated), 32'(want.saturated));
        n_coin += want.coincident;
        n_sat += want.saturated;
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, state_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  stim_row_t rows[$];

  initial begin
    req_if.valid = 1'b0;
    req_if.req_type = gbs_pkg::RQ_ADVANCE;
    req_if.other_mass = '0;
    req_if.other_x = '0;
    req_if.other_y = '0;
    req_if.set_ax = '0;
    req_if.set_ay = '0;
    req_if.load_x = '0;
    req_if.load_y = '0;
    req_if.load_vx = '0;
    req_if.load_vy = '0;
    rsp_if.ready = 1'b0;
    {body_px, body_py, body_vx, body_vy, body_ax, body_ay} = '0;
    grav_reg = gbs_pkg::ONE_Q824;
    step_reg = gbs_pkg::ONE_Q824;

    rows.push_back('{mk_item(gbs_pkg::RQ_ADVANCE, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX,
                             PMIN, PMAX),
                     1, mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
    // other body on top of this one
    rows.push_back('{mk_item(gbs_pkg::RQ_ATTRACT, PMAX, 0, 0, PMAX, PMIN, PMAX, PMIN, PMAX,
                             PMIN),
                     1, mk_res(0, 0, 0, 0, 0, 0, 1, 0)});
    rows.push_back('{mk_item(gbs_pkg::RQ_SETACC, 0, PMAX, PMIN, PMAX, PMIN, 0, 0, 0, 0),
                     1, mk_res(0, 0, 0, 0, PMAX, PMIN, 0, 0)});
    rows.push_back('{mk_item(gbs_pkg::RQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_LOAD, PMAX, PMAX, PMAX, 0, 0, PMAX, PMIN, PMIN, PMAX),
                     1, mk_res(PMAX, PMIN, PMIN, PMAX, PMAX, PMIN, 0, 0)});
    rows.push_back('{mk_item(gbs_pkg::RQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                     1, mk_res(0, 0, 0, 0, PMAX, PMIN, 0, 0)});
    rows.push_back('{mk_item(gbs_pkg::RQ_SETACC, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                     1, mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
    // tiny separation with heavy mass drives the pull into the clamp
    rows.push_back('{mk_item(gbs_pkg::RQ_ATTRACT, PMAX, 1, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_ATTRACT, 32'hffff_ffff, 0, 1, 0, 0, 0, 0, 0, 0),
                     0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_SETACC, 0, 0, 0, 32'h0001_0000, 32'hffff_0000,
                             0, 0, 0, 0),
                     1, mk_res(0, 0, 0, 0, 32'h0001_0000, 32'hffff_0000, 0, 0)});
    rows.push_back('{mk_item(gbs_pkg::RQ_ATTRACT, 0, PMAX, PMIN, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_ATTRACT, 32'h0100_0000, PMIN, PMIN, 0, 0, 0, 0, 0, 0),
                     0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_ATTRACT, 32'h0001_0000, 32'h0003_0000, 32'h0004_0000,
                             0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_LOAD, 0, 0, 0, 0, 0, PMIN, PMAX, 32'h0002_0000, PMIN),
                     0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk_item(gbs_pkg::RQ_ATTRACT, PMAX, PMAX, PMIN, 0, 0, 0, 0, 0, 0), 0, '0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].typed, rows[i].res);
      if ($urandom_range(0, 2) == 0) send_gap($urandom_range(1, 6));
    end
    wait_drained();

    // register extremes, then random settings
    write_reg(gbs_pkg::CFG_GRAV, 32'h0);
    write_reg(gbs_pkg::CFG_TSTEP, 32'hffff_ffff);
    hold_pending = 1;
    run_random(150);
    wait_drained();

    write_reg(gbs_pkg::CFG_GRAV, 32'hffff_ffff);
    write_reg(gbs_pkg::CFG_TSTEP, 32'h0);
    run_random(60);
    // sender pause until everything has come back
    wait_drained();
    run_random(60);
    wait_drained();

    write_reg(gbs_pkg::CFG_GRAV, $urandom);
    write_reg(gbs_pkg::CFG_TSTEP, $urandom >> $urandom_range(0, 12));
    run_random(160);
    wait_drained();

    write_reg(gbs_pkg::CFG_GRAV, gbs_pkg::ONE_Q824);
    write_reg(gbs_pkg::CFG_TSTEP, 32'h0010_0000);
    run_random(160);
    wait_drained();

    // closing stretch at full rate on both sides
    no_idle = 1;
    write_reg(gbs_pkg::CFG_GRAV, $urandom);
    write_reg(gbs_pkg::CFG_TSTEP, $urandom >> 4);
    run_random(160);
    wait_drained();

    $display("covered %0d items over several G/dt settings, extremes included", n_items);
    $display("%0d results checked, %0d coincident, %0d saturated", n_results, n_coin, n_sat);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gbs_pkg.sv
rtl/gbs_if.sv
rtl/gbs_ctrl.sv
rtl/gbs_datapath.sv
rtl/gravity_body_step_top.sv
bench/tb_gravity_body_step_top.sv
